### src/qtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_pkg: shared types and constants of the query text lexer
// Item layouts, event and token codes, and the command record that travels
// from the classifier to the result sequencer.
// ----------------------------------------------------------------------------
package qtl_pkg;

  localparam int MAX_RES     = 6;
  localparam int CNT_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    EV_TEXT = 2'd0,
    EV_END  = 2'd1,
    EV_ERR  = 2'd2
  } event_t;

  typedef enum logic [3:0] {
    TK_IDENT  = 4'd0,
    TK_NUMBER = 4'd1,
    TK_STRING = 4'd2,
    TK_EQ     = 4'd3,
    TK_NE     = 4'd4,
    TK_LT     = 4'd5,
    TK_LE     = 4'd6,
    TK_GT     = 4'd7,
    TK_GE     = 4'd8,
    TK_COMMA  = 4'd9,
    TK_SEMI   = 4'd10,
    TK_LPAREN = 4'd11,
    TK_RPAREN = 4'd12,
    TK_DOT    = 4'd13,
    TK_STAR   = 4'd14,
    TK_EOF    = 4'd15
  } token_t;

  typedef enum logic {
    ERR_UNEXPECTED = 1'b0,
    ERR_UNTERM_STR = 1'b1
  } err_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] text_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] text_out;
    logic [3:0] token_kind;
    logic       error_code;
    logic       last;
  } out_item_t;

  // One result record without the last flag.
  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] text_out;
    logic [3:0] token_kind;
    logic       error_code;
  } rec_t;

  // All records caused by one item, with their count.
  typedef struct packed {
    rec_t [MAX_RES-1:0] recs;
    logic [CNT_W-1:0]   cnt;
  } cmd_t;

endpackage

### src/qtl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_front: lexer classifier
// Accepts one text byte per cycle while the queue has room, advances the lexer
// mode and builds the full list of result records that the item causes.
// ----------------------------------------------------------------------------
module qtl_front
  import qtl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_IDENT = 4'd1,
    M_NUM   = 4'd2,
    M_STAMP = 4'd3,
    M_STR   = 4'd4,
    M_ESC   = 4'd5,
    M_PEND  = 4'd6,
    M_ERR   = 4'd7
  } mode_t;

  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [1:0] OP_EQ   = 2'd0;
  localparam logic [1:0] OP_BANG = 2'd1;
  localparam logic [1:0] OP_LT   = 2'd2;
  localparam logic [1:0] OP_GT   = 2'd3;

  mode_t      mode_r, mode_nxt;
  logic [1:0] op_r, op_nxt;
  cmd_t       cmd_nxt;
  logic [CNT_W-1:0] n;
  logic       to_idle;
  logic       failed;
  logic [7:0] c;
  logic       accept;

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch == CH_SPACE || (ch >= 8'h09 && ch <= 8'h0D);
  endfunction

  function automatic logic is_stamp(input logic [7:0] ch);
    return ch == CH_DOT || ch == CH_DASH || ch == CH_COLON;
  endfunction

  function automatic rec_t mk_text(input logic [7:0] ch);
    rec_t r;
    r            = '0;
    r.event_kind = EV_TEXT;
    r.text_out   = ch;
    return r;
  endfunction

  function automatic rec_t mk_end(input token_t k);
    rec_t r;
    r            = '0;
    r.event_kind = EV_END;
    r.token_kind = k;
    return r;
  endfunction

  function automatic rec_t mk_err(input logic [7:0] ch, input err_t code);
    rec_t r;
    r            = '0;
    r.event_kind = EV_ERR;
    r.text_out   = ch;
    r.error_code = code;
    return r;
  endfunction

  function automatic logic [7:0] op_char(input logic [1:0] op);
    logic [7:0] ch;
    case (op)
      OP_EQ:   ch = CH_EQ;
      OP_BANG: ch = CH_BANG;
      OP_LT:   ch = CH_LT;
      default: ch = CH_GT;
    endcase
    return ch;
  endfunction

  function automatic token_t op_single(input logic [1:0] op);
    token_t k;
    case (op)
      OP_EQ:   k = TK_EQ;
      OP_BANG: k = TK_NE;
      OP_LT:   k = TK_LT;
      default: k = TK_GT;
    endcase
    return k;
  endfunction

  function automatic token_t op_double(input logic [1:0] op);
    token_t k;
    case (op)
      OP_EQ:   k = TK_EQ;
      OP_BANG: k = TK_NE;
      OP_LT:   k = TK_LE;
      default: k = TK_GE;
    endcase
    return k;
  endfunction

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  always_comb begin
    mode_nxt = mode_r;
    op_nxt   = op_r;
    cmd_nxt  = '0;
    n        = '0;
    to_idle  = 1'b0;
    failed   = 1'b0;
    c        = in_item.text_in;

    if (in_item.has_byte) begin
      case (mode_r)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
          end else begin
            cmd_nxt.recs[n] = mk_end(TK_IDENT); n = n + 3'd1;
            to_idle = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(c)) begin
            cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
          end else if (is_stamp(c)) begin
            cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
            mode_nxt = M_STAMP;
          end else begin
            cmd_nxt.recs[n] = mk_end(TK_NUMBER); n = n + 3'd1;
            to_idle = 1'b1;
          end
        end
        M_STAMP: begin
          if (is_digit(c) || is_stamp(c)) begin
            cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
          end else begin
            cmd_nxt.recs[n] = mk_end(TK_IDENT); n = n + 3'd1;
            to_idle = 1'b1;
          end
        end
        M_STR: begin
          if (c == CH_DQUOTE) begin
            cmd_nxt.recs[n] = mk_end(TK_STRING); n = n + 3'd1;
            mode_nxt = M_IDLE;
          end else if (c == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end else begin
            cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
          end
        end
        M_ESC: begin
          cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
          mode_nxt = M_STR;
        end
        M_PEND: begin
          op_nxt = OP_EQ;
          if (c == CH_EQ) begin
            cmd_nxt.recs[n] = mk_text(op_char(op_r)); n = n + 3'd1;
            cmd_nxt.recs[n] = mk_text(CH_EQ); n = n + 3'd1;
            cmd_nxt.recs[n] = mk_end(op_double(op_r)); n = n + 3'd1;
            mode_nxt = M_IDLE;
          end else if (op_r == OP_BANG) begin
            // A bang must be followed by '='.
            cmd_nxt.recs[n] = mk_err(CH_BANG, ERR_UNEXPECTED); n = n + 3'd1;
            mode_nxt = M_ERR;
          end else begin
            cmd_nxt.recs[n] = mk_text(op_char(op_r)); n = n + 3'd1;
            cmd_nxt.recs[n] = mk_end(op_single(op_r)); n = n + 3'd1;
            to_idle = 1'b1;
          end
        end
        M_IDLE: to_idle = 1'b1;
        default: ;
      endcase

      // The byte that closed a token is lexed again from idle.
      if (to_idle) begin
        mode_nxt = M_IDLE;
        if (is_space(c)) begin
          mode_nxt = M_IDLE;
        end else if (is_alpha(c) || c == CH_UNDER) begin
          cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
          mode_nxt = M_IDENT;
        end else if (is_digit(c)) begin
          cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
          mode_nxt = M_NUM;
        end else begin
          case (c)
            CH_DQUOTE: mode_nxt = M_STR;
            CH_EQ: begin
              op_nxt = OP_EQ; mode_nxt = M_PEND;
            end
            CH_BANG: begin
              op_nxt = OP_BANG; mode_nxt = M_PEND;
            end
            CH_LT: begin
              op_nxt = OP_LT; mode_nxt = M_PEND;
            end
            CH_GT: begin
              op_nxt = OP_GT; mode_nxt = M_PEND;
            end
            CH_COMMA: begin
              cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
              cmd_nxt.recs[n] = mk_end(TK_COMMA); n = n + 3'd1;
            end
            CH_SEMI: begin
              cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
              cmd_nxt.recs[n] = mk_end(TK_SEMI); n = n + 3'd1;
            end
            CH_LPAREN: begin
              cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
              cmd_nxt.recs[n] = mk_end(TK_LPAREN); n = n + 3'd1;
            end
            CH_RPAREN: begin
              cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
              cmd_nxt.recs[n] = mk_end(TK_RPAREN); n = n + 3'd1;
            end
            CH_DOT: begin
              cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
              cmd_nxt.recs[n] = mk_end(TK_DOT); n = n + 3'd1;
            end
            CH_STAR: begin
              cmd_nxt.recs[n] = mk_text(c); n = n + 3'd1;
              cmd_nxt.recs[n] = mk_end(TK_STAR); n = n + 3'd1;
            end
            default: begin
              cmd_nxt.recs[n] = mk_err(c, ERR_UNEXPECTED); n = n + 3'd1;
              mode_nxt = M_ERR;
              op_nxt   = OP_EQ;
            end
          endcase
        end
      end
    end

    // End of text flushes whatever the byte left behind.
    if (in_item.end_of_text) begin
      case (mode_nxt)
        M_IDENT, M_STAMP: begin
          cmd_nxt.recs[n] = mk_end(TK_IDENT); n = n + 3'd1;
        end
        M_NUM: begin
          cmd_nxt.recs[n] = mk_end(TK_NUMBER); n = n + 3'd1;
        end
        M_STR, M_ESC: begin
          cmd_nxt.recs[n] = mk_err(8'h00, ERR_UNTERM_STR); n = n + 3'd1;
          failed = 1'b1;
        end
        M_PEND: begin
          if (op_nxt == OP_BANG) begin
            cmd_nxt.recs[n] = mk_err(CH_BANG, ERR_UNEXPECTED); n = n + 3'd1;
            failed = 1'b1;
          end else begin
            cmd_nxt.recs[n] = mk_text(op_char(op_nxt)); n = n + 3'd1;
            cmd_nxt.recs[n] = mk_end(op_single(op_nxt)); n = n + 3'd1;
          end
        end
        M_IDLE: ;
        default: failed = 1'b1;
      endcase
      if (!failed) begin
        cmd_nxt.recs[n] = mk_end(TK_EOF); n = n + 3'd1;
      end
      mode_nxt = M_IDLE;
      op_nxt   = OP_EQ;
    end

    cmd_nxt.cnt = n;
  end

  assign q_push = accept && (n != '0);
  assign q_cmd  = cmd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      op_r   <= OP_EQ;
    end else if (accept) begin
      mode_r <= mode_nxt;
      op_r   <= op_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_empty_item_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_item.has_byte && !in_item.end_of_text) |-> !q_push)
    else $error("item without byte or end produced results");
  a_end_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.end_of_text) |=> (mode_r == M_IDLE && op_r == OP_EQ))
    else $error("lexer not idle after end of text");
`endif

endmodule

### src/qtl_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_cmd_fifo: command queue
// Short queue of per-item record lists between the classifier and the
// result sequencer.
// ----------------------------------------------------------------------------
module qtl_cmd_fifo
  import qtl_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0]   LastIdx = AW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign full_o  = cnt_r == FullCnt;
  assign empty_o = cnt_r == '0;
  assign data_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o))
    else $error("push into full command queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_i && empty_o))
    else $error("pop from empty command queue");
`endif

endmodule

### src/qtl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_back: result sequencer
// Walks the record list at the head of the command queue and hands one
// record per cycle to the output register while it is popped or empty.
// ----------------------------------------------------------------------------
module qtl_back
  import qtl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r;
  out_item_t        out_r;
  logic             load;
  logic             is_last;
  rec_t             cur;

  assign cur     = q_cmd_i.recs[idx_r];
  assign is_last = CNT_W'(idx_r + 1'b1) == q_cmd_i.cnt;
  // The output register refills in the same cycle it is emptied.
  assign load    = !q_empty_i && (!out_valid_r || out_pop);
  assign q_pop_o = load && is_last;
  assign idx_nxt = is_last ? '0 : CNT_W'(idx_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= idx_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= {cur.event_kind, cur.text_out, cur.token_kind, cur.error_code, is_last};
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty_i |-> (idx_r < q_cmd_i.cnt))
    else $error("record index beyond command length");
  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_o |=> (idx_r == '0))
    else $error("record index not rewound after command");
`endif

endmodule

### src/query_text_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_text_lexer_unit: streaming query text lexer
// Byte-serial lexer that emits token text, token-end and error records.
// ----------------------------------------------------------------------------
// One query byte is accepted per cycle while the command queue has room;
// the classifier turns each item into between zero and five result records
// in that cycle. The result sequencer then delivers those records one per
// cycle through a single output register while the consumer keeps popping
// it. The command queue depth (QUEUE_DEPTH_P items) sets how far input may
// run ahead of the result side.
// ----------------------------------------------------------------------------
module query_text_lexer_unit
  import qtl_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wr_cmd, q_rd_cmd;

  qtl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd)
  );

  qtl_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .data_i  (q_wr_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rd_cmd)
  );

  qtl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_rd_cmd),
    .q_pop_o   (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule
